// ===== design/sfcrc_pkg.sv =====
// Shared types and constants for the sync-framed CRC-16 checker.
package sfcrc_pkg;

  localparam logic [7:0] SYNC_RESET   = 8'd250;
  localparam logic [7:0] LENGTH_RESET = 8'd64;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [0:0] {
    REG_SYNC   = 1'b0,
    REG_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic        has_result;
    logic        frame_ok;
    logic [15:0] crc_residue;
  } result_t;

endpackage

// ===== design/sfcrc_apb_regs.sv =====
// APB register file holding the sync byte and the frame length.
module sfcrc_apb_regs
  import sfcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SYNC:   cfg_nxt.sync_byte    = pwdata[7:0];
        REG_LENGTH: cfg_nxt.frame_length = pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte    <= SYNC_RESET;
      cfg_r.frame_length <= LENGTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC:   prdata = {{(CFG_DW-8){1'b0}}, cfg_r.sync_byte};
      REG_LENGTH: prdata = {{(CFG_DW-8){1'b0}}, cfg_r.frame_length};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/sfcrc_crc16.sv =====
// Byte-wise CRC-16-CCITT update, polynomial 0x1021, no reflection.
module sfcrc_crc16
  import sfcrc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  logic [15:0] x0;
  logic [15:0] x1;
  logic [15:0] x2;
  logic [15:0] x3;

  always_comb begin
    // swap bytes, fold in the data byte, then the three shifted folds
    x0 = {crc_in[7:0], crc_in[15:8]} ^ {8'h00, data_in};
    x1 = x0 ^ {12'h000, x0[7:4]};
    x2 = x1 ^ {x1[3:0], 12'h000};
    x3 = x2 ^ {3'b000, x2[7:0], 5'b00000};
    crc_out = x3;
  end

endmodule

// ===== design/sfcrc_frame_core.sv =====
// Frame tracker: sync hunt, byte count and running CRC, one byte per step.
module sfcrc_frame_core
  import sfcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;
  logic [7:0]  seen_next_cnt;
  logic [15:0] crc_next_val;
  logic        started;
  logic        done;

  sfcrc_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    started       = in_frame_r | (rx_byte == cfg.sync_byte);
    seen_next_cnt = in_frame_r ? (seen_r + 8'd1) : 8'd1;
    crc_next_val  = in_frame_r ? crc_upd : 16'h0000;
    done          = started & (seen_next_cnt >= cfg.frame_length);

    res.has_result  = done;
    res.crc_residue = crc_next_val;
    res.frame_ok    = (crc_next_val == 16'h0000);

    in_frame_nxt = in_frame_r;
    seen_nxt     = seen_r;
    crc_nxt      = crc_r;
    if (step && started) begin
      crc_nxt = crc_next_val;
      if (done) begin
        in_frame_nxt = 1'b0;
        seen_nxt     = 8'd0;
      end else begin
        in_frame_nxt = 1'b1;
        seen_nxt     = seen_next_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      seen_r     <= 8'd0;
      crc_r      <= 16'h0000;
    end else begin
      in_frame_r <= in_frame_nxt;
      seen_r     <= seen_nxt;
      crc_r      <= crc_nxt;
    end
  end

  // a hunting tracker always has a cleared byte count
  a_hunt_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (seen_r == 8'd0))
    else $error("byte count not cleared while hunting");

endmodule

// ===== design/sync_frame_crc16_checker_unit.sv =====
// Top level of the sync-framed CRC-16 frame checker.
//
// Usage:
//   in_*  : byte stream, one received byte per word in in_tdata[7:0].
//   out_* : one word per completed frame; out_tdata[0] is frame_ok (residue
//           is zero), out_tdata[16:1] is the CRC residue, upper bits zero.
//   cfg_* : APB port; 0x0 sync byte (reset 0xFA), 0x4 frame length
//           (reset 64, counts the sync byte and both CRC bytes).
// The block hunts for the sync byte, then runs CRC-16/XMODEM over the rest
// of the frame and reports on its last byte. Sync bytes inside a frame are
// plain data. Words that end no frame produce no output.
// Timing: an accepted byte lands in the input register; the edge on which it
// advances runs the CRC step and loads the output register. One byte per
// cycle is sustained while no stall holds the input register; the single
// XOR-network CRC step between input and output register sets it.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and returns to sync hunt.
// Stall: while out_tready is low and a result waits, a byte that would end
// another frame holds in the input register and in_tready drops; bytes
// that end no frame keep flowing.
module sync_frame_crc16_checker_unit
  import sfcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [0] frame_ok, [16:1] crc_residue, [23:17] zero
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t        cfg;
  result_t     res;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r;
  logic [15:0] out_crc_r;
  logic        step;
  logic        in_fire;

  sfcrc_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfcrc_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // advance the held byte unless it ends a frame and the output slot is busy
  assign step      = s1_valid_r & (~res.has_result | ~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | step;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step && res.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
    if (step && res.has_result) begin
      out_ok_r  <= res.frame_ok;
      out_crc_r <= res.crc_residue;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_crc_r, out_ok_r};

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.has_result) |=> out_valid_r)
    else $error("finished frame did not reach the output register");

  a_ok_matches_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_crc_r == 16'h0000)))
    else $error("frame_ok disagrees with the residue");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input refused with an empty input register");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("blocked byte was lost or changed");

endmodule

// ===== dv/frame_check_pkg.sv =====
// Frame verdict predictor and result checker for the sync-framed CRC-16 bench.
package frame_check_pkg;

  import sfcrc_pkg::*;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic        ok;
    logic [15:0] residue;
  } frame_verdict_t;

  // Byte-wise CRC-16/XMODEM step, shifted out one bit at a time.
  function automatic logic [15:0] crc16_xmodem_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  class frame_check_board;
    logic [7:0]     sync_val;
    logic [7:0]     len_val;
    bit             in_frame;
    logic [7:0]     seen;
    logic [15:0]    crc;
    frame_verdict_t verdicts_due[$];
    int             errors;

    function new();
      sync_val = SYNC_RESET;
      len_val  = LENGTH_RESET;
      in_frame = 1'b0;
      seen     = 8'd0;
      crc      = 16'h0000;
      errors   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] v);
      case (idx)
        REG_SYNC:   sync_val = v;
        REG_LENGTH: len_val  = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Advance the frame tracker by one accepted word.
    function void take_byte(logic [7:0] b);
      frame_verdict_t v;
      if (!in_frame) begin
        if (b != sync_val) return;
        crc      = 16'h0000;
        seen     = 8'd1;
        in_frame = 1'b1;
      end else begin
        crc  = crc16_xmodem_byte(crc, b);
        seen = seen + 8'd1;
      end
      if (seen >= len_val) begin
        v.ok      = (crc == 16'h0000);
        v.residue = crc;
        verdicts_due.push_back(v);
        in_frame = 1'b0;
        seen     = 8'd0;
      end
    endfunction

    // Compare one result word against the oldest verdict due.
    function void match_verdict(logic [23:0] word);
      frame_verdict_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due: frame_ok=%0b residue=%04h",
                 $time, word[0], word[16:1]);
        return;
      end
      want = verdicts_due.pop_front();
      if (word[0] !== want.ok) begin
        errors++;
        $display("%0t: frame_ok expected %0b actual %0b", $time, want.ok, word[0]);
      end
      if (word[16:1] !== want.residue) begin
        errors++;
        $display("%0t: crc_residue expected %04h actual %04h",
                 $time, want.residue, word[16:1]);
      end
    endfunction
  endclass

endpackage

// ===== dv/testbench.sv =====
// Stimulus, handshake monitor and end-of-run verdict for the frame checker.
module testbench;

  import sfcrc_pkg::*;
  import frame_check_pkg::*;

  localparam int ITEMS       = 1850;
  localparam int CYCLE_LIMIT = 600000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // [7:0] rx_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // [0] frame_ok, [16:1] crc_residue, [23:17] zero
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  frame_check_board sb;
  bit               calm = 1'b0;   // set near the end: no more idling
  int               random_bytes;
  int               phase_bytes;

  sync_frame_crc16_checker_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both handshakes on the edge; values seen here are the pre-edge ones.
  // Check the result first: it always belongs to a word taken earlier.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.match_verdict(out_tdata);
      if (in_tvalid && in_tready)   sb.take_byte(in_tdata);
    end
  end

  // Result side: random stall bursts, then plain ready once the run goes calm.
  initial begin
    int hold;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        hold = $urandom_range(1, 24);
        out_tready <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Cap the run length in cycles.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one word, optionally after an idle burst; hold valid until taken.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every result due, then let the pipeline drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then release the bus.
  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Build a frame at the current sync and length: from length 3 up, a random
  // payload closed by its CRC, high byte first; an intact one leaves a zero
  // residue. Optionally flip one bit after the sync byte, or cut the frame short.
  task automatic send_frame(input int len, input bit corrupt, input bit cut);
    logic [7:0]  body[$];
    logic [15:0] c;
    int          pos;
    int          stop;
    body.push_back(sb.sync_val);
    if (len >= 3) begin
      c = 16'h0000;
      for (int i = 0; i < len - 3; i++) begin
        body.push_back(8'($urandom_range(0, 255)));
        c = crc16_xmodem_byte(c, body[body.size() - 1]);
      end
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
    end else if (len == 2) begin
      body.push_back(8'($urandom_range(0, 255)));
    end
    if (corrupt && body.size() > 1) begin
      pos = $urandom_range(1, body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    stop = body.size();
    if (cut && body.size() > 1) stop = $urandom_range(1, body.size() - 1);
    for (int i = 0; i < stop; i++) begin
      send_byte(body[i]);
      random_bytes++;
      phase_bytes++;
    end
  endtask

  initial begin
    int         goal;
    int         pick;
    int         long_phases;
    logic [7:0] new_sync;
    logic [7:0] new_len;

    sb = new();
    random_bytes = 0;
    long_phases  = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Shortest legal frame: noise while hunting, zero-residue frame,
    // sync value as data, all-ones data.
    cfg_write(REG_SYNC, 8'hA5);
    cfg_write(REG_LENGTH, 8'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hA5); send_byte(8'hA5); send_byte(8'hFF);
    send_byte(8'hA5); send_byte(8'hFF); send_byte(8'hFF);
    settle();

    // Lengths 0 and 1: the sync byte alone closes the frame.
    cfg_write(REG_LENGTH, 8'd0);
    send_byte(8'hA5);
    send_byte(8'h11);
    settle();
    cfg_write(REG_LENGTH, 8'd1);
    send_byte(8'hA5);
    settle();
    cfg_write(REG_LENGTH, 8'd2);
    send_byte(8'hA5); send_byte(8'h80);
    settle();

    // Change sync and shorten the length while a frame is open: the open
    // frame keeps going and ends on its next word; the new sync applies after.
    cfg_write(REG_LENGTH, 8'd8);
    send_byte(8'hA5); send_byte(8'h01); send_byte(8'h02);
    settle();
    cfg_write(REG_SYNC, 8'h3C);
    cfg_write(REG_LENGTH, 8'd2);
    send_byte(8'h03);
    send_byte(8'hA5);
    send_byte(8'h3C); send_byte(8'h7E);
    settle();

    // Random phases: mostly well-formed frames, some corrupted or cut short,
    // mixed with noise. Each phase ends drained, sometimes mid-frame.
    while (random_bytes < ITEMS) begin
      case ($urandom_range(0, 7))
        0:       new_sync = 8'h00;
        1:       new_sync = 8'hFF;
        default: new_sync = 8'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 11);
      if (pick == 0 && long_phases < 3) begin
        new_len = 8'd255;
        long_phases++;
      end else if (pick <= 2) begin
        new_len = 8'($urandom_range(0, 2));
      end else if (pick == 3) begin
        new_len = 8'd3;
      end else begin
        new_len = 8'($urandom_range(3, 24));
      end
      if ($urandom_range(0, 3) != 0) cfg_write(REG_SYNC, new_sync);
      if ($urandom_range(0, 3) != 0) cfg_write(REG_LENGTH, new_len);

      goal = $urandom_range(30, 150);
      phase_bytes = 0;
      while (phase_bytes < goal && random_bytes < ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          send_frame(sb.len_val, $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        if (random_bytes > ITEMS * 17 / 20) calm = 1'b1;
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfcrc_pkg.sv
design/sfcrc_apb_regs.sv
design/sfcrc_crc16.sv
design/sfcrc_frame_core.sv
design/sync_frame_crc16_checker_unit.sv
dv/frame_check_pkg.sv
dv/testbench.sv
